// ===== sv/tch_pkg.sv =====
// Shared types, constants and the arctangent table for the compass heading block.
// No dependencies; every other file refers to it by scoped names.
package tch_pkg;

  // CORDIC iteration count (8 to 24 steps)
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 5;   // index into the 24-entry table

  // serial multiplier operand and product widths
  localparam int MUL_W     = 36;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int MUL_CNT_W = 6;

  // CORDIC datapath widths
  localparam int CX_W  = 56;
  localparam int ANG_W = 34;

  localparam logic signed [CX_W-1:0]  CORDIC_GAIN_Q30 = 56'sd652032874;
  localparam logic signed [ANG_W-1:0] HALF_PI         = 34'sh0_4000_0000;
  localparam logic signed [ANG_W-1:0] PI_ANG          = 34'sh0_8000_0000;

  // configuration register indexes
  localparam logic [2:0] REG_X_OFF = 3'd0;
  localparam logic [2:0] REG_Y_OFF = 3'd1;
  localparam logic [2:0] REG_Z_OFF = 3'd2;
  localparam logic [2:0] REG_X_SCL = 3'd3;
  localparam logic [2:0] REG_Y_SCL = 3'd4;
  localparam logic [2:0] REG_Z_SCL = 3'd5;
  localparam logic [2:0] REG_MODE  = 3'd6;

  typedef struct packed {
    logic [15:0]        raw_x_word;
    logic [15:0]        raw_z_word;
    logic [15:0]        raw_y_word;
    logic               read_complete;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic               read_failed;
    logic [15:0]        failure_count;
  } out_word_t;

  typedef struct packed {
    logic                   start;
    logic                   vec_mode;
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_rsp_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] p;
  } mul_rsp_t;

  // atan(2^-i) as a binary angle, 2^31 equals pi
  function automatic logic signed [ANG_W-1:0] atan_val(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10680862;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41721;
      5'd15:   v = 34'sd20860;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2607;
      5'd19:   v = 34'sd1303;
      5'd20:   v = 34'sd651;
      5'd21:   v = 34'sd325;
      5'd22:   v = 34'sd162;
      5'd23:   v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/tilt_compensated_compass_heading.sv =====
// Top level of the tilt-compensated compass: register file, sequencer, output register.
// Depends on tch_pkg, tch_smul and tch_cordic.
//
// Use: each word on the in_ channel (valid/ready) is one magnetometer read with
// roll and pitch. Each accepted word yields exactly one word on the out_ channel:
// the held heading, a failed-read flag and the saturating failure count.
// Offsets, scales and the mode are written through cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while the block is idle, which the block itself
// does not enforce; writes take effect at once.
// In angle mode a word takes ten products on the bit-serial multiplier, two
// CORDIC rotation runs and one vectoring run, skipped when the field is zero.
// In raw mode a word skips the multiplier and CORDIC. The block takes no new word
// until the sequencer is back in idle; it is then taken while the previous result
// may still wait in the output register. A stalled receiver holds that register,
// and once a second result is ready the sequencer waits for the first to be taken.
// Reset (synchronous, active low) clears the raw vector, heading and count, and
// loads offsets 0, scales 1.0 and angle mode.
module tilt_compensated_compass_heading (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tch_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tch_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_GO, S_MUL_WAIT, S_ROT_GO, S_ROT_WAIT, S_VEC_GO, S_VEC_WAIT, S_FIN
  } state_t;

  state_t state_r;

  logic signed [15:0] off_r [3];
  logic [15:0]        scl_r [3];
  logic               mode_r;
  logic signed [15:0] raw_r [3];
  logic [15:0]        held_r;
  logic [15:0]        tally_r;
  logic signed [15:0] roll_r, pitch_r;
  logic               fail_r;

  logic signed [18:0]                 m_r [3];
  logic signed [tch_pkg::ANG_W-1:0]   sr_r, cr_r, sp_r, cp_r, t_r, u_r;
  logic signed [tch_pkg::CX_W-1:0]    mx_r, my_r;
  logic [3:0]                         job_r;
  logic                               pitch_sel_r;
  logic                               flip_r;
  logic                               out_valid_r;
  tch_pkg::out_word_t                 out_r;

  tch_pkg::cordic_req_t               c_req;
  tch_pkg::cordic_rsp_t               c_rsp;
  tch_pkg::mul_rsp_t                  m_rsp;
  logic signed [tch_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [16:0]                 d0, d1, d2;
  logic signed [35:0]                 rnd;
  logic signed [15:0]                 ang;
  logic signed [tch_pkg::ANG_W-1:0]   zs, zf;
  logic                               over;
  logic signed [tch_pkg::CX_W-1:0]    vx, vy;
  logic signed [tch_pkg::ANG_W-1:0]   ry, rx;
  logic [31:0]                        zr;
  logic                               in_acc;

  function automatic logic signed [15:0] neg_sat(input logic [15:0] v);
    return (v == 16'h8000) ? 16'sh7fff : 16'(-signed'(v));
  endfunction

  tch_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_MUL_GO),
    .a     (mul_a),
    .b     (mul_b),
    .rsp   (m_rsp)
  );

  tch_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (c_req),
    .rsp   (c_rsp)
  );

  assign in_ready = state_r == S_IDLE;
  assign in_acc   = in_valid && in_ready;

  // calibration differences
  assign d0 = 17'(raw_r[0]) - 17'(off_r[0]);
  assign d1 = 17'(raw_r[1]) - 17'(off_r[1]);
  assign d2 = 17'(raw_r[2]) - 17'(off_r[2]);

  // pick multiplier operands for the current product
  always_comb begin
    case (job_r)
      4'd0:    begin mul_a = 36'(d0);     mul_b = 36'({1'b0, scl_r[0]}); end
      4'd1:    begin mul_a = 36'(d1);     mul_b = 36'({1'b0, scl_r[1]}); end
      4'd2:    begin mul_a = 36'(d2);     mul_b = 36'({1'b0, scl_r[2]}); end
      4'd3:    begin mul_a = 36'(sr_r);   mul_b = 36'(sp_r); end
      4'd4:    begin mul_a = 36'(cr_r);   mul_b = 36'(sp_r); end
      4'd5:    begin mul_a = 36'(m_r[0]); mul_b = 36'(cp_r); end
      4'd6:    begin mul_a = 36'(m_r[1]); mul_b = 36'(t_r);  end
      4'd7:    begin mul_a = 36'(m_r[2]); mul_b = 36'(u_r);  end
      4'd8:    begin mul_a = 36'(m_r[1]); mul_b = 36'(cr_r); end
      4'd9:    begin mul_a = 36'(m_r[2]); mul_b = 36'(sr_r); end
      default: begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  // round the scaled axis: floor((p + 8192) / 16384)
  assign rnd = m_rsp.p[35:0] + 36'd8192;

  // fold the angle into +-pi/2 before rotation
  assign ang  = pitch_sel_r ? pitch_r : roll_r;
  assign zs   = 34'(signed'({ang, 16'h0000}));
  assign over = (zs > tch_pkg::HALF_PI) || (zs < -tch_pkg::HALF_PI);
  assign zf   = (zs > 0) ? zs - tch_pkg::PI_ANG : zs + tch_pkg::PI_ANG;

  // vectoring input, turned by pi when x is negative
  assign vx = mx_r;
  assign vy = -my_r;

  always_comb begin
    c_req = '0;
    if (state_r == S_ROT_GO) begin
      c_req.start    = 1'b1;
      c_req.vec_mode = 1'b0;
      c_req.x        = tch_pkg::CORDIC_GAIN_Q30;
      c_req.y        = '0;
      c_req.z        = over ? zf : zs;
    end else if (state_r == S_VEC_GO) begin
      c_req.start    = (vx != 0) || (vy != 0);
      c_req.vec_mode = 1'b1;
      c_req.x        = (vx < 0) ? -vx : vx;
      c_req.y        = (vx < 0) ? -vy : vy;
      c_req.z        = (vx < 0) ? tch_pkg::PI_ANG : '0;
    end
  end

  assign ry = flip_r ? -c_rsp.y[tch_pkg::ANG_W-1:0] : c_rsp.y[tch_pkg::ANG_W-1:0];
  assign rx = flip_r ? -c_rsp.x[tch_pkg::ANG_W-1:0] : c_rsp.x[tch_pkg::ANG_W-1:0];
  assign zr = c_rsp.z[31:0] + 32'h0000_8000;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= '0;
      scl_r[0] <= 16'd16384;
      scl_r[1] <= 16'd16384;
      scl_r[2] <= 16'd16384;
      mode_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        tch_pkg::REG_X_OFF: off_r[0] <= cfg_wdata;
        tch_pkg::REG_Y_OFF: off_r[1] <= cfg_wdata;
        tch_pkg::REG_Z_OFF: off_r[2] <= cfg_wdata;
        tch_pkg::REG_X_SCL: scl_r[0] <= cfg_wdata;
        tch_pkg::REG_Y_SCL: scl_r[1] <= cfg_wdata;
        tch_pkg::REG_Z_SCL: scl_r[2] <= cfg_wdata;
        tch_pkg::REG_MODE:  mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer, working state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      raw_r[0]    <= '0;
      raw_r[1]    <= '0;
      raw_r[2]    <= '0;
      held_r      <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken; in S_FIN the register is refilled instead
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.read_complete) begin
              raw_r[0] <= in_data.raw_x_word;
              raw_r[1] <= neg_sat(in_data.raw_y_word);
              raw_r[2] <= neg_sat(in_data.raw_z_word);
            end else if (tally_r != 16'hffff) begin
              tally_r <= tally_r + 1'b1;
            end
            roll_r      <= in_data.roll_angle;
            pitch_r     <= in_data.pitch_angle;
            fail_r      <= !in_data.read_complete;
            job_r       <= '0;
            pitch_sel_r <= 1'b0;
            state_r     <= mode_r ? S_MUL_GO : S_FIN;
          end
        end
        S_MUL_GO: state_r <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (m_rsp.done) begin
            case (job_r)
              4'd0, 4'd1, 4'd2: m_r[job_r[1:0]] <= 19'(rnd >>> 14);
              4'd3: t_r  <= m_rsp.p[63:30];
              4'd4: u_r  <= m_rsp.p[63:30];
              4'd5: mx_r <= m_rsp.p[tch_pkg::CX_W-1:0];
              4'd6, 4'd7: mx_r <= mx_r + m_rsp.p[tch_pkg::CX_W-1:0];
              4'd8: my_r <= m_rsp.p[tch_pkg::CX_W-1:0];
              4'd9: my_r <= my_r - m_rsp.p[tch_pkg::CX_W-1:0];
              default: ;
            endcase
            job_r <= job_r + 1'b1;
            if (job_r == 4'd2) begin
              state_r <= S_ROT_GO;
            end else if (job_r == 4'd9) begin
              state_r <= S_VEC_GO;
            end else begin
              state_r <= S_MUL_GO;
            end
          end
        end
        S_ROT_GO: begin
          flip_r  <= over;
          state_r <= S_ROT_WAIT;
        end
        S_ROT_WAIT: begin
          if (c_rsp.done) begin
            if (!pitch_sel_r) begin
              sr_r        <= ry;
              cr_r        <= rx;
              pitch_sel_r <= 1'b1;
              state_r     <= S_ROT_GO;
            end else begin
              sp_r    <= ry;
              cp_r    <= rx;
              state_r <= S_MUL_GO;
            end
          end
        end
        S_VEC_GO: begin
          if (c_req.start) begin
            state_r <= S_VEC_WAIT;
          end else begin
            held_r  <= '0;
            state_r <= S_FIN;
          end
        end
        S_VEC_WAIT: begin
          if (c_rsp.done) begin
            held_r  <= zr[31:16];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_r.heading       <= held_r;
            out_r.read_failed   <= fail_r;
            out_r.failure_count <= tally_r;
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a product finishes only while the sequencer waits for it
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    m_rsp.done |-> state_r == S_MUL_WAIT)
    else $error("multiplier finished outside its wait state");

  // a CORDIC run finishes only while the sequencer waits for it
  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    c_rsp.done |-> (state_r == S_ROT_WAIT || state_r == S_VEC_WAIT))
    else $error("CORDIC finished outside its wait state");

  // the failure count never falls
  a_tally_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> tally_r >= $past(tally_r))
    else $error("failure count decreased");

  // raw mode keeps the held heading
  a_raw_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !mode_r |=> held_r == $past(held_r))
    else $error("heading changed in raw mode");

endmodule

// ===== sv/tch_smul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, MUL_W bits a product.
// Depends on tch_pkg.
module tch_smul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [tch_pkg::MUL_W-1:0]   a,
  input  logic signed [tch_pkg::MUL_W-1:0]   b,
  output tch_pkg::mul_rsp_t                  rsp
);

  logic [tch_pkg::PROD_W-1:0]    mc_r;
  logic [tch_pkg::MUL_W-1:0]     mp_r;
  logic [tch_pkg::PROD_W-1:0]    acc_r;
  logic [tch_pkg::MUL_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic                          last;

  assign last = cnt_r == tch_pkg::MUL_CNT_W'(tch_pkg::MUL_W - 1);

  // shift multiplier bits out LSB first; the top bit carries negative weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mc_r   <= tch_pkg::PROD_W'(a);
        mp_r   <= b;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (mp_r[0]) begin
          acc_r <= last ? acc_r - mc_r : acc_r + mc_r;
        end
        mc_r  <= mc_r << 1;
        mp_r  <= mp_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

// ===== sv/tch_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on tch_pkg for widths, step count and the arctangent table.
module tch_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tch_pkg::cordic_req_t req,
  output tch_pkg::cordic_rsp_t rsp
);

  logic signed [tch_pkg::CX_W-1:0]  x_r, y_r, dx, dy;
  logic signed [tch_pkg::ANG_W-1:0] z_r, a;
  logic [tch_pkg::STEP_W-1:0]       i_r;
  logic                             vec_r;
  logic                             busy_r;
  logic                             done_r;
  logic                             neg;
  logic                             last;

  assign dx   = y_r >>> i_r;
  assign dy   = x_r >>> i_r;
  assign a    = tch_pkg::atan_val(i_r);
  assign neg  = vec_r ? (y_r > 0) : (z_r < 0);
  assign last = i_r == tch_pkg::STEP_W'(tch_pkg::CORDIC_STEPS - 1);

  // load on start, then advance one step a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        x_r    <= req.x;
        y_r    <= req.y;
        z_r    <= req.z;
        vec_r  <= req.vec_mode;
        i_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (neg) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + a;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - a;
        end
        i_r <= i_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.x    = x_r;
  assign rsp.y    = y_r;
  assign rsp.z    = z_r;

endmodule
